@@ hw/rtl/lrfu_pkg.sv @@
// Shared constants, codes and the fractional decay table of the LRFU store.
// No dependencies; used by lrfu_decay and lrfu_cache_replacement.
package lrfu_pkg;

   localparam int WEIGHT_W = 32;
   localparam int TIME_W   = 32;
   localparam int CAP_W    = 7;
   localparam int LAM_W    = 9;
   localparam int FAC_W    = 17;
   localparam int MODE_W   = 2;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 32'h0001_0000;
   localparam logic [CAP_W-1:0]    CAP_RESET  = 7'd64;
   localparam logic [LAM_W-1:0]    LAM_RESET  = 9'd128;

   // request codes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ACCESS = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

   // register indexes
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_LAMBDA   = 1'b1;

   // round(2^-(2^k/256) * 65536)
   function automatic logic [15:0] frac_tab(input logic [2:0] k);
      logic [15:0] r;
      case (k)
         3'd0: r = 16'd65359;
         3'd1: r = 16'd65182;
         3'd2: r = 16'd64830;
         3'd3: r = 16'd64132;
         3'd4: r = 16'd62757;
         3'd5: r = 16'd60097;
         3'd6: r = 16'd55109;
         3'd7: r = 16'd46341;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/lrfu_decay.sv @@
// Pipelined weight decay: w * 2^-(elapsed*lambda/256) in Q16.16, eleven stages.
// Uses lrfu_pkg for widths and the fractional table; carries a tag along.
module lrfu_decay #(
   parameter int TAG_W = 96
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [lrfu_pkg::TIME_W-1:0]     in_elapsed,
   input  logic [lrfu_pkg::LAM_W-1:0]      in_lambda,
   input  logic [lrfu_pkg::WEIGHT_W-1:0]   in_weight,
   input  logic [TAG_W-1:0]                in_tag,
   output logic                            out_valid,
   output logic [lrfu_pkg::WEIGHT_W-1:0]   out_decayed,
   output logic [TAG_W-1:0]                out_tag
);

   localparam int P_W = lrfu_pkg::TIME_W + lrfu_pkg::LAM_W;
   localparam int NSTG = 9;

   // stage 0 holds the exponent split, stages 1..8 apply one table factor each
   logic                           sv_ff  [NSTG];
   logic [lrfu_pkg::FAC_W-1:0]     sfac_ff[NSTG];
   logic [7:0]                     sf_ff  [NSTG];
   logic                           sbig_ff[NSTG];
   logic [4:0]                     sn_ff  [NSTG];
   logic [lrfu_pkg::WEIGHT_W-1:0]  sw_ff  [NSTG];
   logic [TAG_W-1:0]               stag_ff[NSTG];

   logic [lrfu_pkg::FAC_W-1:0]     fac_in [NSTG];
   logic [P_W-1:0]                 p;

   logic                           cv_ff;
   logic [33:0]                    cm_ff;
   logic                           cbig_ff;
   logic [4:0]                     cn_ff;
   logic [TAG_W-1:0]               ctag_ff;
   logic [49:0]                    cprod;

   logic                           ov_ff;
   logic [lrfu_pkg::WEIGHT_W-1:0]  od_ff;
   logic [TAG_W-1:0]               otag_ff;

   assign p = P_W'(in_elapsed) * P_W'(in_lambda);

   // next factor for each table stage
   always_comb begin
      logic [32:0] prod;
      fac_in[0] = sfac_ff[0];
      for (int j = 1; j < NSTG; j++) begin
         prod = 33'(sfac_ff[j-1]) * 33'(lrfu_pkg::frac_tab(3'(NSTG - 1 - j)));
         prod = prod + 33'd32768;
         if (sf_ff[j-1][NSTG-1-j]) begin
            fac_in[j] = prod[32:16];
         end else begin
            fac_in[j] = sfac_ff[j-1];
         end
      end
   end

   assign cprod = 50'(sw_ff[NSTG-1]) * 50'(sfac_ff[NSTG-1]) + 50'd32768;

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NSTG; j++) begin
            sv_ff[j] <= 1'b0;
         end
         cv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         sv_ff[0] <= in_valid;
         for (int j = 1; j < NSTG; j++) begin
            sv_ff[j] <= sv_ff[j-1];
         end
         cv_ff <= sv_ff[NSTG-1];
         ov_ff <= cv_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      sfac_ff[0] <= lrfu_pkg::FAC_W'(lrfu_pkg::WEIGHT_ONE);
      sf_ff[0]   <= p[7:0];
      sbig_ff[0] <= |p[P_W-1:13];
      sn_ff[0]   <= p[12:8];
      sw_ff[0]   <= in_weight;
      stag_ff[0] <= in_tag;
      for (int j = 1; j < NSTG; j++) begin
         sfac_ff[j] <= fac_in[j];
         sf_ff[j]   <= sf_ff[j-1];
         sbig_ff[j] <= sbig_ff[j-1];
         sn_ff[j]   <= sn_ff[j-1];
         sw_ff[j]   <= sw_ff[j-1];
         stag_ff[j] <= stag_ff[j-1];
      end
      cm_ff   <= cprod[49:16];
      cbig_ff <= sbig_ff[NSTG-1];
      cn_ff   <= sn_ff[NSTG-1];
      ctag_ff <= stag_ff[NSTG-1];
      if (cbig_ff) begin
         od_ff <= '0;
      end else begin
         od_ff <= lrfu_pkg::WEIGHT_W'(cm_ff >> cn_ff);
      end
      otag_ff <= ctag_ff;
   end

   assign out_valid   = ov_ff;
   assign out_decayed = od_ff;
   assign out_tag     = otag_ff;

endmodule

@@ hw/rtl/lrfu_cache_replacement.sv @@
// LRFU block store: an insert with room, or any other item on an empty store, answers in the
// next cycle; lookup, access and a full-store insert scan the stored entries through the
// one-entry-per-cycle read port, and eviction and access hits use the decay pipeline as well.
// One item at a time; busy is high while it runs. Results cannot be stalled.
// Synchronous reset empties the store (count, time and order counters zero), capacity 64,
// lambda 128; the entry memories are not cleared and are only read below the count.
module lrfu_cache_replacement #(
   parameter int MAX_ENTRIES = 64,
   parameter int ID_BITS     = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [lrfu_pkg::MODE_W-1:0]        req_mode,
   input  logic [ID_BITS-1:0]                 req_file_id,
   input  logic [ID_BITS-1:0]                 req_seg_id,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic                               rsp_evicted_valid,
   output logic [ID_BITS-1:0]                 rsp_evicted_file_id,
   output logic [ID_BITS-1:0]                 rsp_evicted_seg_id,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [2:0]                         csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CW    = (CNT_W > lrfu_pkg::CAP_W) ? CNT_W : lrfu_pkg::CAP_W;
   localparam int TW    = lrfu_pkg::TIME_W;
   localparam int TAG_W = TW + IDX_W + 2 * ID_BITS;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EVICT = 3'd1;
   localparam logic [2:0] ST_MATCH = 3'd2;
   localparam logic [2:0] ST_ACCRD = 3'd3;
   localparam logic [2:0] ST_ACCW  = 3'd4;
   localparam logic [2:0] ST_CLEAR = 3'd5;

   typedef struct packed {
      logic [ID_BITS-1:0] fid;
      logic [ID_BITS-1:0] sid;
      logic [TW-1:0]      last;
      logic [TW-1:0]      order;
   } meta_type;

   // entry memories
   meta_type                        meta_mem [MAX_ENTRIES];
   logic [lrfu_pkg::WEIGHT_W-1:0]   wt_mem   [MAX_ENTRIES];

   logic [2:0]                      st_ff, st_in;
   logic [lrfu_pkg::MODE_W-1:0]     mode_ff, mode_in;
   logic [ID_BITS-1:0]              fid_ff, fid_in, sid_ff, sid_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in, iss_ff, iss_in, rcv_ff, rcv_in;
   logic [TW-1:0]                   time_ff, time_in, seq_ff, seq_in;
   logic [lrfu_pkg::CAP_W-1:0]      cap_ff, cap_in;
   logic [lrfu_pkg::LAM_W-1:0]      lam_ff, lam_in;
   logic                            rdv_ff, rdv_in;
   logic [IDX_W-1:0]                rdaddr_ff, rdaddr_in;
   logic                            bv_ff, bv_in;
   logic [lrfu_pkg::WEIGHT_W-1:0]   bw_ff, bw_in;
   logic [TW-1:0]                   bage_ff, bage_in;
   logic [IDX_W-1:0]                bidx_ff, bidx_in;
   logic [ID_BITS-1:0]              bfid_ff, bfid_in, bsid_ff, bsid_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_hit_ff, rsp_hit_in, rsp_ev_ff, rsp_ev_in;
   logic [ID_BITS-1:0]              rsp_fid_ff, rsp_fid_in, rsp_sid_ff, rsp_sid_in;

   meta_type                        rd_meta_ff;
   logic [lrfu_pkg::WEIGHT_W-1:0]   rd_w_ff;
   logic                            rd_go;
   logic [IDX_W-1:0]                rd_addr;
   logic                            wr_meta_en, wr_w_en;
   logic [IDX_W-1:0]                wr_addr;
   meta_type                        wr_meta;
   logic [lrfu_pkg::WEIGHT_W-1:0]   wr_w;

   logic                            pipe_in_v, pipe_out_v;
   logic [TAG_W-1:0]                pipe_in_tag, pipe_out_tag;
   logic [lrfu_pkg::WEIGHT_W-1:0]   pipe_d;
   logic [TW-1:0]                   po_age;
   logic [IDX_W-1:0]                po_idx;
   logic [ID_BITS-1:0]              po_fid, po_sid;

   logic [CW-1:0]                   cap_ext, cap_eff, cnt_ext;
   logic                            full;
   logic                            csr_wr;
   logic [TW-1:0]                   rd_age;
   logic                            last_rcv;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == lrfu_pkg::REG_LAMBDA) ? 32'(lam_ff) : 32'(cap_ff);

   // effective capacity: zero acts as one, clamp to the store size
   assign cap_ext = CW'(cap_ff);
   assign cnt_ext = CW'(cnt_ff);
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CW'(1);
      end else if (cap_ext > CW'(MAX_ENTRIES)) begin
         cap_eff = CW'(MAX_ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
   end
   assign full = (cnt_ext >= cap_eff) && (cnt_ff != '0);

   // decay pipeline, fed from memory read data
   assign rd_age      = seq_ff - rd_meta_ff.order;
   assign pipe_in_tag = {rd_age, rdaddr_ff, rd_meta_ff.fid, rd_meta_ff.sid};
   assign {po_age, po_idx, po_fid, po_sid} = pipe_out_tag;
   assign pipe_in_v   = rdv_ff && (st_ff == ST_EVICT || st_ff == ST_ACCW);

   lrfu_decay #(
      .TAG_W (TAG_W)
   ) u_decay (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (pipe_in_v),
      .in_elapsed  (time_ff - rd_meta_ff.last),
      .in_lambda   (lam_ff),
      .in_weight   (rd_w_ff),
      .in_tag      (pipe_in_tag),
      .out_valid   (pipe_out_v),
      .out_decayed (pipe_d),
      .out_tag     (pipe_out_tag)
   );

   assign last_rcv = (rcv_ff + CNT_W'(1)) == cnt_ff;

   // sequencer
   always_comb begin
      logic               take;
      logic               found;
      logic [IDX_W-1:0]   fidx;
      logic [32:0]        sum;
      st_in        = st_ff;
      mode_in      = mode_ff;
      fid_in       = fid_ff;
      sid_in       = sid_ff;
      cnt_in       = cnt_ff;
      iss_in       = iss_ff;
      rcv_in       = rcv_ff;
      time_in      = time_ff;
      seq_in       = seq_ff;
      cap_in       = cap_ff;
      lam_in       = lam_ff;
      bv_in        = bv_ff;
      bw_in        = bw_ff;
      bage_in      = bage_ff;
      bidx_in      = bidx_ff;
      bfid_in      = bfid_ff;
      bsid_in      = bsid_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_fid_in   = rsp_fid_ff;
      rsp_sid_in   = rsp_sid_ff;
      rd_go        = 1'b0;
      rd_addr      = iss_ff[IDX_W-1:0];
      wr_meta_en   = 1'b0;
      wr_w_en      = 1'b0;
      wr_addr      = iss_ff[IDX_W-1:0];
      wr_meta      = '0;
      wr_w         = '0;
      take         = 1'b0;
      found        = 1'b0;
      fidx         = bidx_ff;
      sum          = '0;

      if (csr_wr) begin
         if (csr_paddr[2] == lrfu_pkg::REG_CAPACITY) begin
            cap_in = csr_pwdata[lrfu_pkg::CAP_W-1:0];
         end else begin
            lam_in = csr_pwdata[lrfu_pkg::LAM_W-1:0];
         end
      end

      case (st_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in = req_mode;
               fid_in  = req_file_id;
               sid_in  = req_seg_id;
               iss_in  = '0;
               rcv_in  = '0;
               bv_in   = 1'b0;
               case (req_mode)
                  lrfu_pkg::MODE_INSERT: begin
                     if (full) begin
                        st_in = ST_EVICT;
                     end else begin
                        wr_meta_en   = 1'b1;
                        wr_w_en      = 1'b1;
                        wr_addr      = cnt_ff[IDX_W-1:0];
                        wr_meta      = '{req_file_id, req_seg_id, time_ff, seq_ff};
                        wr_w         = lrfu_pkg::WEIGHT_ONE;
                        cnt_in       = cnt_ff + CNT_W'(1);
                        time_in      = time_ff + TW'(1);
                        seq_in       = seq_ff + TW'(1);
                        rsp_valid_in = 1'b1;
                        rsp_hit_in   = 1'b0;
                        rsp_ev_in    = 1'b0;
                        rsp_fid_in   = '0;
                        rsp_sid_in   = '0;
                     end
                  end
                  lrfu_pkg::MODE_ACCESS, lrfu_pkg::MODE_LOOKUP: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_hit_in   = 1'b0;
                        rsp_ev_in    = 1'b0;
                        rsp_fid_in   = '0;
                        rsp_sid_in   = '0;
                     end else begin
                        st_in = ST_MATCH;
                     end
                  end
                  default: begin
                     if (cnt_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_hit_in   = 1'b0;
                        rsp_ev_in    = 1'b0;
                        rsp_fid_in   = '0;
                        rsp_sid_in   = '0;
                     end else begin
                        st_in = ST_CLEAR;
                     end
                  end
               endcase
            end
         end

         ST_EVICT: begin
            // issue reads, track the smallest decayed weight, oldest on ties
            if (iss_ff < cnt_ff) begin
               rd_go  = 1'b1;
               iss_in = iss_ff + CNT_W'(1);
            end
            if (pipe_out_v) begin
               take = !bv_ff || (pipe_d < bw_ff) || (pipe_d == bw_ff && po_age > bage_ff);
               if (take) begin
                  bv_in   = 1'b1;
                  bw_in   = pipe_d;
                  bage_in = po_age;
                  bidx_in = po_idx;
                  bfid_in = po_fid;
                  bsid_in = po_sid;
               end
               rcv_in = rcv_ff + CNT_W'(1);
               if (last_rcv) begin
                  // replace the victim in place with the new block
                  wr_meta_en   = 1'b1;
                  wr_w_en      = 1'b1;
                  wr_addr      = take ? po_idx : bidx_ff;
                  wr_meta      = '{fid_ff, sid_ff, time_ff, seq_ff};
                  wr_w         = lrfu_pkg::WEIGHT_ONE;
                  time_in      = time_ff + TW'(1);
                  seq_in       = seq_ff + TW'(1);
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b0;
                  rsp_ev_in    = 1'b1;
                  rsp_fid_in   = take ? po_fid : bfid_ff;
                  rsp_sid_in   = take ? po_sid : bsid_ff;
                  st_in        = ST_IDLE;
               end
            end
         end

         ST_MATCH: begin
            // scan for the oldest copy of the block
            if (iss_ff < cnt_ff) begin
               rd_go  = 1'b1;
               iss_in = iss_ff + CNT_W'(1);
            end
            if (rdv_ff) begin
               take = (rd_meta_ff.fid == fid_ff) && (rd_meta_ff.sid == sid_ff)
                      && (!bv_ff || rd_age > bage_ff);
               if (take) begin
                  bv_in   = 1'b1;
                  bage_in = rd_age;
                  bidx_in = rdaddr_ff;
               end
               rcv_in = rcv_ff + CNT_W'(1);
               if (last_rcv) begin
                  found = bv_ff || take;
                  fidx  = take ? rdaddr_ff : bidx_ff;
                  if (mode_ff == lrfu_pkg::MODE_LOOKUP || !found) begin
                     rsp_valid_in = 1'b1;
                     rsp_hit_in   = found;
                     rsp_ev_in    = 1'b0;
                     rsp_fid_in   = '0;
                     rsp_sid_in   = '0;
                     st_in        = ST_IDLE;
                  end else begin
                     bidx_in = fidx;
                     st_in   = ST_ACCRD;
                  end
               end
            end
         end

         ST_ACCRD: begin
            rd_go   = 1'b1;
            rd_addr = bidx_ff;
            st_in   = ST_ACCW;
         end

         ST_ACCW: begin
            // write back decayed weight plus one, saturating
            if (pipe_out_v) begin
               sum = 33'(pipe_d) + 33'(lrfu_pkg::WEIGHT_ONE);
               wr_meta_en   = 1'b1;
               wr_w_en      = 1'b1;
               wr_addr      = bidx_ff;
               wr_meta      = '{rd_meta_ff.fid, rd_meta_ff.sid, time_ff, rd_meta_ff.order};
               wr_w         = sum[32] ? '1 : sum[31:0];
               time_in      = time_ff + TW'(1);
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b1;
               rsp_ev_in    = 1'b0;
               rsp_fid_in   = '0;
               rsp_sid_in   = '0;
               st_in        = ST_IDLE;
            end
         end

         ST_CLEAR: begin
            // zero one weight per cycle
            wr_w_en = 1'b1;
            wr_w    = '0;
            iss_in  = iss_ff + CNT_W'(1);
            if ((iss_ff + CNT_W'(1)) == cnt_ff) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = 1'b0;
               rsp_ev_in    = 1'b0;
               rsp_fid_in   = '0;
               rsp_sid_in   = '0;
               st_in        = ST_IDLE;
            end
         end

         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   assign rdv_in    = rd_go;
   assign rdaddr_in = rd_addr;

   // entry memories: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_meta_en) begin
         meta_mem[wr_addr] <= wr_meta;
      end
      if (wr_w_en) begin
         wt_mem[wr_addr] <= wr_w;
      end
      if (rd_go) begin
         rd_meta_ff <= meta_mem[rd_addr];
         rd_w_ff    <= wt_mem[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         cnt_ff       <= '0;
         iss_ff       <= '0;
         rcv_ff       <= '0;
         time_ff      <= '0;
         seq_ff       <= '0;
         cap_ff       <= lrfu_pkg::CAP_RESET;
         lam_ff       <= lrfu_pkg::LAM_RESET;
         rdv_ff       <= 1'b0;
         bv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         iss_ff       <= iss_in;
         rcv_ff       <= rcv_in;
         time_ff      <= time_in;
         seq_ff       <= seq_in;
         cap_ff       <= cap_in;
         lam_ff       <= lam_in;
         rdv_ff       <= rdv_in;
         bv_ff        <= bv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      fid_ff     <= fid_in;
      sid_ff     <= sid_in;
      rdaddr_ff  <= rdaddr_in;
      bw_ff      <= bw_in;
      bage_ff    <= bage_in;
      bidx_ff    <= bidx_in;
      bfid_ff    <= bfid_in;
      bsid_ff    <= bsid_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_ev_ff  <= rsp_ev_in;
      rsp_fid_ff <= rsp_fid_in;
      rsp_sid_ff <= rsp_sid_in;
   end

   assign busy                = (st_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_evicted_valid   = rsp_ev_ff;
   assign rsp_evicted_file_id = rsp_fid_ff;
   assign rsp_evicted_seg_id  = rsp_sid_ff;

`ifndef NO_ASSERTIONS
   a_hit_ev_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_ev_ff))
      else $error("hit and eviction reported together");

   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above store size");

   a_rcv_le_iss: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_EVICT || st_ff == ST_MATCH) |-> rcv_ff <= iss_ff)
      else $error("more scan results than reads issued");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> st_ff == ST_IDLE)
      else $error("item delivered while sequencer busy");
`endif

endmodule
